FILE: rtl/mplt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC port learning table - shared definitions
// Types, codes and helpers used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package mplt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int HASH_BUCKETS      = 256;
	localparam int HASH_W            = 8;

	// register index, paddr[2]
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_MAXHELD = 1'b1;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_LEARN  = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;
	localparam logic [1:0] OP_AGE    = 2'd3;

	localparam logic [3:0] ST_RESOLVED = 4'd0;
	localparam logic [3:0] ST_HELD     = 4'd1;
	localparam logic [3:0] ST_DROPPED  = 4'd2;
	localparam logic [3:0] ST_NEW      = 4'd3;
	localparam logic [3:0] ST_UPDATED  = 4'd4;
	localparam logic [3:0] ST_RELEASED = 4'd5;
	localparam logic [3:0] ST_FULL     = 4'd6;
	localparam logic [3:0] ST_BADPORT  = 4'd7;
	localparam logic [3:0] ST_DONE     = 4'd8;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_BKT, S_WALK, S_HIT, S_MISS, S_CFX,
		S_APP, S_FIN, S_FL, S_FRD, S_AG, S_ARD, S_OUT
	} state_t;

	typedef enum logic [1:0] {RD_BKT, RD_CHN, RD_HEAD, RD_NXT} rd_sel_t;

	typedef enum logic [2:0] {
		EW_NONE, EW_LOOK_HIT, EW_LEARN_HIT, EW_NEW_LOOK, EW_NEW_LEARN, EW_AGE_SEEN
	} ent_wr_t;

	typedef struct packed {
		logic [47:0] addr;
		logic [2:0]  port;
		logic        res;
		logic        seen;
		logic [31:0] last;
		logic [7:0]  held;
	} ent_t;

	typedef struct packed {
		logic       load;
		logic       bkt_rd;
		logic       rd_en;
		rd_sel_t    rd_sel;
		ent_wr_t    ent_wr;
		logic       alloc;
		logic       ch_ins;
		logic       ch_fix;
		logic       lru_unl;
		logic       lru_app;
		logic       lru_fin;
		logic       del;
		logic       drop1;
		logic       scan;
		logic       st_we;
		logic [3:0] st;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       mask_ok;
		logic       bkt_hit;
		logic       mtch;
		logic       chn_nil;
		logic       nxt_nil;
		logic       head_nil;
		logic       res;
		logic       seen;
		logic       port_eq;
		logic       aged;
		logic       held_ok;
		logic       full;
		logic       out_free;
	} dp_sts_t;

	function automatic logic [HASH_W-1:0] addr_hash(input logic [47:0] a);
		addr_hash = a[47:40] ^ a[39:32] ^ a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
	endfunction

endpackage

FILE: rtl/mplt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC port learning table - controller
// Sequences hash chain walks, LRU relinking and table sweeps.
// ----------------------------------------------------------------------------
module mplt_ctrl import mplt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_BKT;
		cmd.ent_wr = EW_NONE;
		cmd.st     = ST_DONE;
		in_stall   = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.op)
					OP_LOOKUP: begin
						cmd.bkt_rd = 1'b1;
						state_d    = S_BKT;
					end
					OP_LEARN: begin
						if (!sts.mask_ok) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_BADPORT;
							state_d   = S_OUT;
						end else begin
							cmd.bkt_rd = 1'b1;
							state_d    = S_BKT;
						end
					end
					OP_FLUSH, OP_AGE: begin
						if (sts.head_nil) begin
							state_d = S_OUT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_HEAD;
							state_d    = (sts.op == OP_FLUSH) ? S_FL : S_AG;
						end
					end
				endcase
			end
			S_BKT: begin
				if (sts.bkt_hit) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_BKT;
					state_d    = S_WALK;
				end else begin
					state_d = S_MISS;
				end
			end
			S_WALK: begin
				if (sts.mtch) begin
					state_d = S_HIT;
				end else if (sts.chn_nil) begin
					state_d = S_MISS;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_CHN;
				end
			end
			S_HIT: begin
				cmd.lru_unl = 1'b1;
				cmd.st_we   = 1'b1;
				if (sts.op == OP_LOOKUP) begin
					cmd.ent_wr = EW_LOOK_HIT;
					cmd.drop1  = !sts.res && !sts.held_ok;
					cmd.st     = sts.res ? ST_RESOLVED : (sts.held_ok ? ST_HELD : ST_DROPPED);
				end else begin
					cmd.ent_wr = EW_LEARN_HIT;
					cmd.st     = sts.res ? ST_UPDATED : ST_RELEASED;
				end
				state_d = S_APP;
			end
			S_MISS: begin
				cmd.st_we = 1'b1;
				if (sts.op == OP_LOOKUP && !sts.held_ok) begin
					cmd.drop1 = 1'b1;
					cmd.st    = ST_DROPPED;
					state_d   = S_OUT;
				end else if (sts.full) begin
					cmd.drop1 = (sts.op == OP_LOOKUP);
					cmd.st    = ST_FULL;
					state_d   = S_OUT;
				end else begin
					cmd.alloc  = 1'b1;
					cmd.ch_ins = 1'b1;
					if (sts.op == OP_LOOKUP) begin
						cmd.ent_wr = EW_NEW_LOOK;
						cmd.scan   = 1'b1;
						cmd.st     = ST_HELD;
					end else begin
						cmd.ent_wr = EW_NEW_LEARN;
						cmd.st     = ST_NEW;
					end
					state_d = sts.bkt_hit ? S_CFX : S_APP;
				end
			end
			S_CFX: begin
				cmd.ch_fix = 1'b1;
				state_d    = S_APP;
			end
			S_APP: begin
				cmd.lru_app = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				cmd.lru_fin = 1'b1;
				state_d     = S_OUT;
			end
			S_FL: begin
				cmd.del = sts.port_eq;
				state_d = sts.nxt_nil ? S_OUT : S_FRD;
			end
			S_FRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NXT;
				state_d    = S_FL;
			end
			S_AG: begin
				if (!sts.aged) begin
					state_d = S_OUT;
				end else begin
					if (sts.seen) begin
						cmd.ent_wr = EW_AGE_SEEN;
					end else begin
						cmd.del = 1'b1;
					end
					state_d = sts.nxt_nil ? S_OUT : S_ARD;
				end
			end
			S_ARD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NXT;
				state_d    = S_AG;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: rtl/mplt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC port learning table - datapath
// Entry store, LRU and hash chain links, free list, counters, result register.
// ----------------------------------------------------------------------------
module mplt_dp import mplt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  op,
	input  logic [47:0] mac_addr,
	input  logic [5:0]  port_mask,
	input  logic [2:0]  port,
	input  logic [31:0] now,
	input  logic [30:0] remove_timeout,
	input  logic [7:0]  max_held_packets,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [2:0]  port_out,
	output logic [7:0]  released_count,
	output logic [6:0]  removed_count,
	output logic [7:0]  dropped_count,
	output logic        scan_request,
	output logic [31:0] dropped_total
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int LW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [LW-1:0] NIL = LW'(TABLE_ENTRIES);

	// captured item
	logic [1:0]  op_q;
	logic [47:0] mac_q;
	logic [5:0]  mask_q;
	logic [2:0]  fport_q;
	logic [31:0] now_q, thr_q;

	// stores
	ent_t          ent_mem [TABLE_ENTRIES];
	logic [LW-1:0] nxt_mem [TABLE_ENTRIES];
	logic [LW-1:0] prv_mem [TABLE_ENTRIES];
	logic [LW-1:0] chn_mem [TABLE_ENTRIES];
	logic [LW-1:0] chp_mem [TABLE_ENTRIES];
	logic [IW-1:0] fstk_mem [TABLE_ENTRIES];
	logic [LW-1:0] bkt_mem [HASH_BUCKETS];
	logic [HASH_BUCKETS-1:0] bkt_vld_q;

	ent_t          ent_rd_q;
	logic [LW-1:0] nxt_rd_q, prv_rd_q, chn_rd_q, chp_rd_q, bkt_rd_q;
	logic          bkt_hv_q;
	logic [IW-1:0] fstk_rd_q, cur_q, new_q;
	logic          new_sel_q;
	logic [LW-1:0] fsp_q, fill_q, head_q, tail_q;
	logic [7:0]    held_q;
	logic [31:0]   drops_q;

	// per-item result accumulation
	logic [3:0] st_q;
	logic [2:0] pout_q;
	logic [7:0] rel_q, drp_q;
	logic [6:0] rmv_q;
	logic       scan_q;
	logic       out_valid_q;

	logic [IW-1:0] rd_idx, tgt, aidx;
	logic [LW-1:0] fsp_dec;
	logic [HASH_W-1:0] mhash, ehash;
	logic [2:0] pidx;
	logic [31:0] diff;
	logic p_v, n_v, t_v, pc_v, cn_v, held_ok, full;

	logic          ent_we, nxt_we, prv_we, chn_we, chp_we, bkt_we, bkt_wv;
	ent_t          ent_wd;
	logic [IW-1:0] ent_wa, nxt_wa, prv_wa, chn_wa, chp_wa;
	logic [LW-1:0] nxt_wd, prv_wd, chn_wd, chp_wd, bkt_wd;
	logic [HASH_W-1:0] bkt_wa;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			mac_q   <= mac_addr;
			mask_q  <= port_mask;
			fport_q <= port;
			now_q   <= now;
			thr_q   <= now - {1'b0, remove_timeout};
		end
	end

	always_comb begin
		pidx = '0;
		for (int k = 0; k < 6; k++) begin
			if (mask_q[k]) pidx = 3'(k);
		end
	end

	assign mhash   = addr_hash(mac_q);
	assign ehash   = addr_hash(ent_rd_q.addr);
	assign p_v     = prv_rd_q < NIL;
	assign n_v     = nxt_rd_q < NIL;
	assign t_v     = tail_q < NIL;
	assign pc_v    = chp_rd_q < NIL;
	assign cn_v    = chn_rd_q < NIL;
	assign held_ok = held_q < max_held_packets;
	assign full    = (fill_q == NIL) && (fsp_q == '0);
	assign tgt     = new_sel_q ? new_q : cur_q;
	assign fsp_dec = fsp_q - LW'(1);
	assign aidx    = (fsp_q != '0) ? fstk_rd_q : fill_q[IW-1:0];
	// wrapping signed age: (now - timeout) - last
	assign diff    = thr_q - ent_rd_q.last;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_BKT:  rd_idx = bkt_rd_q[IW-1:0];
			RD_CHN:  rd_idx = chn_rd_q[IW-1:0];
			RD_HEAD: rd_idx = head_q[IW-1:0];
			RD_NXT:  rd_idx = nxt_rd_q[IW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			cur_q    <= rd_idx;
			ent_rd_q <= ent_mem[rd_idx];
			nxt_rd_q <= nxt_mem[rd_idx];
			prv_rd_q <= prv_mem[rd_idx];
			chn_rd_q <= chn_mem[rd_idx];
			chp_rd_q <= chp_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bkt_rd) begin
			bkt_rd_q <= bkt_mem[mhash];
			bkt_hv_q <= bkt_vld_q[mhash];
		end
	end

	always_ff @(posedge clk) begin
		fstk_rd_q <= fstk_mem[fsp_dec[IW-1:0]];
	end

	// entry record write
	always_comb begin
		ent_we = 1'b1;
		ent_wa = cur_q;
		ent_wd = ent_rd_q;
		unique case (cmd.ent_wr)
			EW_NONE: ent_we = 1'b0;
			EW_LOOK_HIT: begin
				ent_wd.last = now_q;
				if (!ent_rd_q.res && held_ok) ent_wd.held = ent_rd_q.held + 8'd1;
			end
			EW_LEARN_HIT: begin
				if (ent_rd_q.held != 8'd0) ent_wd.last = now_q;
				ent_wd.port = pidx;
				ent_wd.seen = 1'b1;
				if (!ent_rd_q.res) begin
					ent_wd.res  = 1'b1;
					ent_wd.held = 8'd0;
				end
			end
			EW_NEW_LOOK: begin
				ent_wa = aidx;
				ent_wd = '{addr: mac_q, port: 3'd0, res: 1'b0, seen: 1'b0,
				           last: now_q, held: 8'd1};
			end
			EW_NEW_LEARN: begin
				ent_wa = aidx;
				ent_wd = '{addr: mac_q, port: pidx, res: 1'b1, seen: 1'b0,
				           last: now_q, held: 8'd0};
			end
			EW_AGE_SEEN: ent_wd.seen = 1'b0;
			default: ent_we = 1'b0;
		endcase
	end

	// LRU links
	always_comb begin
		nxt_we = 1'b0;
		nxt_wa = cur_q;
		nxt_wd = NIL;
		prv_we = 1'b0;
		prv_wa = cur_q;
		prv_wd = NIL;
		if (cmd.lru_unl || cmd.del) begin
			nxt_we = p_v;
			nxt_wa = prv_rd_q[IW-1:0];
			nxt_wd = nxt_rd_q;
			prv_we = n_v;
			prv_wa = nxt_rd_q[IW-1:0];
			prv_wd = prv_rd_q;
		end else if (cmd.lru_app) begin
			nxt_we = t_v;
			nxt_wa = tail_q[IW-1:0];
			nxt_wd = LW'(tgt);
			prv_we = 1'b1;
			prv_wa = tgt;
			prv_wd = tail_q;
		end else if (cmd.lru_fin) begin
			nxt_we = 1'b1;
			nxt_wa = tgt;
			nxt_wd = NIL;
		end
	end

	// hash chain links (doubly linked so a delete needs no chain walk)
	always_comb begin
		chn_we = 1'b0;
		chn_wa = cur_q;
		chn_wd = NIL;
		chp_we = 1'b0;
		chp_wa = cur_q;
		chp_wd = NIL;
		bkt_we = 1'b0;
		bkt_wa = mhash;
		bkt_wd = LW'(aidx);
		bkt_wv = 1'b1;
		if (cmd.ch_ins) begin
			chn_we = 1'b1;
			chn_wa = aidx;
			chn_wd = (op_q == OP_LOOKUP && bkt_hv_q) ? bkt_rd_q : NIL;
			chp_we = 1'b1;
			chp_wa = aidx;
			chp_wd = (op_q == OP_LEARN && bkt_hv_q) ? LW'(cur_q) : NIL;
			bkt_we = (op_q == OP_LOOKUP) || !bkt_hv_q;
		end else if (cmd.ch_fix) begin
			// lookup inserts at chain head, learn appends at chain tail
			if (op_q == OP_LEARN) begin
				chn_we = 1'b1;
				chn_wa = cur_q;
				chn_wd = LW'(new_q);
			end else begin
				chp_we = 1'b1;
				chp_wa = bkt_rd_q[IW-1:0];
				chp_wd = LW'(new_q);
			end
		end else if (cmd.del) begin
			chn_we = pc_v;
			chn_wa = chp_rd_q[IW-1:0];
			chn_wd = chn_rd_q;
			chp_we = cn_v;
			chp_wa = chn_rd_q[IW-1:0];
			chp_wd = chp_rd_q;
			bkt_we = !pc_v;
			bkt_wa = ehash;
			bkt_wd = chn_rd_q;
			bkt_wv = cn_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
	end

	always_ff @(posedge clk) begin
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
	end

	always_ff @(posedge clk) begin
		if (chn_we) chn_mem[chn_wa] <= chn_wd;
	end

	always_ff @(posedge clk) begin
		if (chp_we) chp_mem[chp_wa] <= chp_wd;
	end

	always_ff @(posedge clk) begin
		if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.del) fstk_mem[fsp_q[IW-1:0]] <= cur_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) new_q <= aidx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_vld_q <= '0;
			fsp_q     <= '0;
			fill_q    <= '0;
			new_sel_q <= 1'b0;
			head_q    <= NIL;
			tail_q    <= NIL;
			held_q    <= '0;
			drops_q   <= '0;
		end else begin
			if (bkt_we) bkt_vld_q[bkt_wa] <= bkt_wv;

			if (cmd.load) new_sel_q <= 1'b0;
			if (cmd.alloc) begin
				new_sel_q <= 1'b1;
				if (fsp_q != '0) fsp_q <= fsp_dec;
				else fill_q <= fill_q + LW'(1);
			end else if (cmd.del) begin
				fsp_q <= fsp_q + LW'(1);
			end

			if (cmd.lru_unl || cmd.del) begin
				if (!p_v) head_q <= nxt_rd_q;
				if (!n_v) tail_q <= prv_rd_q;
			end else if (cmd.lru_app) begin
				if (!t_v) head_q <= LW'(tgt);
				tail_q <= LW'(tgt);
			end

			if ((cmd.ent_wr == EW_LOOK_HIT && !ent_rd_q.res && held_ok) ||
			    cmd.ent_wr == EW_NEW_LOOK) begin
				held_q <= held_q + 8'd1;
			end else if ((cmd.ent_wr == EW_LEARN_HIT && !ent_rd_q.res) || cmd.del) begin
				held_q <= (held_q >= ent_rd_q.held) ? held_q - ent_rd_q.held : 8'd0;
			end

			if (cmd.drop1) drops_q <= drops_q + 32'd1;
			else if (cmd.del) drops_q <= drops_q + 32'(ent_rd_q.held);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			st_q   <= ST_DONE;
			pout_q <= '0;
			rel_q  <= '0;
			rmv_q  <= '0;
			drp_q  <= '0;
			scan_q <= 1'b0;
		end else begin
			if (cmd.st_we) st_q <= cmd.st;
			if (cmd.ent_wr == EW_LOOK_HIT && ent_rd_q.res) pout_q <= ent_rd_q.port;
			if (cmd.ent_wr == EW_LEARN_HIT && !ent_rd_q.res) rel_q <= ent_rd_q.held;
			if (cmd.drop1) drp_q <= 8'd1;
			if (cmd.del) begin
				drp_q <= drp_q + ent_rd_q.held;
				rmv_q <= rmv_q + 7'd1;
			end
			if (cmd.scan) scan_q <= 1'b1;
		end
	end

	// result register: frees the core while the transfer waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status         <= st_q;
			port_out       <= pout_q;
			released_count <= rel_q;
			removed_count  <= rmv_q;
			dropped_count  <= drp_q;
			scan_request   <= scan_q;
			dropped_total  <= drops_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts          = '0;
		sts.op       = op_q;
		sts.mask_ok  = $onehot(mask_q);
		sts.bkt_hit  = bkt_hv_q;
		sts.mtch     = (ent_rd_q.addr == mac_q);
		sts.chn_nil  = !cn_v;
		sts.nxt_nil  = !n_v;
		sts.head_nil = !(head_q < NIL);
		sts.res      = ent_rd_q.res;
		sts.seen     = ent_rd_q.seen;
		sts.port_eq  = (ent_rd_q.port == fport_q);
		sts.aged     = !diff[31];
		sts.held_ok  = held_ok;
		sts.full     = full;
		sts.out_free = !out_valid_q || !out_stall;
	end

`ifndef NO_ASSERTIONS
	a_free_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fsp_q <= fill_q) else $error("free list deeper than allocated entries");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NIL) else $error("fill count beyond table size");
	a_lru_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < NIL) == (tail_q < NIL)) else $error("LRU head and tail disagree");
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !full) else $error("allocation from a full table");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q) else $error("result not presented after emit");
`endif

endmodule

FILE: rtl/mac_port_learning_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC port learning table
// Hashed MAC-to-port table with LRU aging, held-packet accounting and APB
// configuration registers.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_stall  | op, mac_addr, port_mask, port, now
//  out      | out_valid / out_stall| status, port_out, released_count,
//           |                      | removed_count, dropped_count,
//           |                      | scan_request, dropped_total
//  cfg      | APB psel / penable   | paddr, pwdata, prdata
//
// One item at a time. Lookup or learn walks the hash chain of the address up to
// its position, each chain step being one read of the entry store; a new entry
// adds a chain fix-up state when its bucket is occupied. Flush walks the whole
// LRU list from its head; age tick walks it until the first entry not yet aged.
// Reset leaves the table empty at once; no clearing sweep is needed.
// The result sits in an output register, so the next item is taken while a
// finished transfer is still stalled.
// ----------------------------------------------------------------------------
module mac_port_learning_table import mplt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [47:0] mac_addr,
	input  logic [5:0]  port_mask,
	input  logic [2:0]  port,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [2:0]  port_out,
	output logic [7:0]  released_count,
	output logic [6:0]  removed_count,
	output logic [7:0]  dropped_count,
	output logic        scan_request,
	output logic [31:0] dropped_total,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [30:0] timeout_q;
	logic [7:0]  maxheld_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 31'd1000;
			maxheld_q <= 8'd64;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_TIMEOUT: timeout_q <= pwdata[30:0];
				REG_MAXHELD: maxheld_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TIMEOUT: prdata = {1'b0, timeout_q};
			REG_MAXHELD: prdata = {24'd0, maxheld_q};
		endcase
	end

	mplt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mplt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.op               (op),
		.mac_addr         (mac_addr),
		.port_mask        (port_mask),
		.port             (port),
		.now              (now),
		.remove_timeout   (timeout_q),
		.max_held_packets (maxheld_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.port_out         (port_out),
		.released_count   (released_count),
		.removed_count    (removed_count),
		.dropped_count    (dropped_count),
		.scan_request     (scan_request),
		.dropped_total    (dropped_total)
	);

endmodule
